FILE: hw/rtl/ltr_pkg.sv
// Shared types, constants and keyword table of the lexical token recognizer.
`timescale 1ns / 1ps

package ltr_pkg;

    // Text and token limits.
    localparam int TEXT_POSITIONS  = 65536;
    localparam int MAX_TOKEN_BYTES = 255;

    localparam int POS_W = $clog2(TEXT_POSITIONS);
    localparam int RUN_W = $clog2(MAX_TOKEN_BYTES + 1);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_POSITIONS - 1);
    localparam logic [RUN_W-1:0] RUN_MAX  = RUN_W'(MAX_TOKEN_BYTES);

    // Port field widths.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CODE_W  = 8;
    localparam int IDN_W   = 16;
    localparam int START_W = 16;
    localparam int LEN_W   = 8;

    localparam logic [IDN_W-1:0] IDN_MAX = {IDN_W{1'b1}};

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELOP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ARITH   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd6;

    // Relational operator codes.
    localparam logic [CODE_W-1:0] REL_GT  = 8'd0;
    localparam logic [CODE_W-1:0] REL_LT  = 8'd1;
    localparam logic [CODE_W-1:0] REL_EQ  = 8'd2;
    localparam logic [CODE_W-1:0] REL_NE  = 8'd3;
    localparam logic [CODE_W-1:0] REL_GE  = 8'd4;
    localparam logic [CODE_W-1:0] REL_LE  = 8'd5;
    localparam logic [CODE_W-1:0] REL_UNK = 8'd6;

    // Keyword table: if then else while int float return.
    localparam int KW_COUNT   = 7;
    localparam int KW_IDX_W   = 3;
    localparam int KW_SLOTS   = 8;
    localparam int KW_LEN_W   = 4;

    localparam logic [BYTE_W-1:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd5, 4'd6
    };

    // Queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [IDN_W-1:0]   idn;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_token;

    // All tokens caused by one input byte: one or two.
    typedef struct packed {
        logic   has_two;
        t_token tok0;
        t_token tok1;
    } t_entry;

endpackage

FILE: hw/rtl/ltr_front.sv
// Scanner front end: classifies each byte, tracks the open token and builds queue entries.
`timescale 1ns / 1ps

module ltr_front
    import ltr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_last_byte,
    input  logic              i_space,
    output logic              o_push,
    output t_entry            o_entry
);

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_RELOP  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic   valid;
        logic   ident;
        t_token tok;
    } t_flush;

    t_mode                r_mode, n_mode;
    logic [BYTE_W-1:0]    r_rf, n_rf;
    logic [KW_COUNT-1:0]  r_km, n_km;
    logic [RUN_W-1:0]     r_rl, n_rl;
    logic [POS_W-1:0]     r_rs, n_rs;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [IDN_W-1:0]     r_idc, n_idc;
    logic                 r_stopped, n_stopped;

    logic                 accept;
    logic [1:0]           n_cnt;
    t_token               tok_list [2];
    t_flush               f_a, f_b, f_c;
    logic                 consumed;
    logic                 do_new;
    logic [BYTE_W-1:0]    c;
    logic                 c_alpha, c_digit, c_space, c_under;

    function automatic logic [START_W-1:0] rep_pos(input logic [POS_W-1:0] p);
        logic [POS_W+START_W-1:0] ext;
        ext = {{START_W{1'b0}}, p};
        if (ext > (POS_W+START_W)'({START_W{1'b1}})) begin
            return {START_W{1'b1}};
        end
        return ext[START_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] rep_len(input logic [RUN_W-1:0] l);
        logic [RUN_W+LEN_W-1:0] ext;
        ext = {{LEN_W{1'b0}}, l};
        if (ext > (RUN_W+LEN_W)'({LEN_W{1'b1}})) begin
            return {LEN_W{1'b1}};
        end
        return ext[LEN_W-1:0];
    endfunction

    function automatic logic [KW_COUNT-1:0] extend_match(input logic [KW_COUNT-1:0] km,
                                                          input logic [RUN_W-1:0] rl,
                                                          input logic [BYTE_W-1:0] ch);
        logic [KW_COUNT-1:0] res;
        res = km;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (rl >= RUN_W'(KW_LEN[k]) || KW_TEXT[k][rl[KW_IDX_W-1:0]] != ch) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] rl);
        return (rl < RUN_MAX) ? rl + 1'b1 : rl;
    endfunction

    function automatic logic [IDN_W-1:0] idn_inc(input logic [IDN_W-1:0] v);
        return (v != IDN_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic t_token one_byte(input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] ch,
                                        input logic [POS_W-1:0] pos);
        t_token t;
        t.kind  = kind;
        t.code  = ch;
        t.idn   = '0;
        t.start = rep_pos(pos);
        t.len   = LEN_W'(1);
        return t;
    endfunction

    // Closes the open token, if there is one.
    function automatic t_flush flush_run(input t_mode mode,
                                         input logic [KW_COUNT-1:0] km,
                                         input logic [RUN_W-1:0] rl,
                                         input logic [POS_W-1:0] rs,
                                         input logic [BYTE_W-1:0] rf,
                                         input logic [IDN_W-1:0] idc);
        t_flush f;
        logic hit;
        logic [KW_IDX_W-1:0] kidx;
        f    = '0;
        hit  = 1'b0;
        kidx = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (km[k] && rl == RUN_W'(KW_LEN[k])) begin
                hit  = 1'b1;
                kidx = KW_IDX_W'(k);
            end
        end
        f.tok.start = rep_pos(rs);
        f.tok.len   = rep_len(rl);
        unique case (mode)
            MODE_IDENT: begin
                f.valid = 1'b1;
                if (hit) begin
                    f.tok.kind = KIND_KEYWORD;
                    f.tok.code = CODE_W'(kidx);
                end else begin
                    f.tok.kind = KIND_IDENT;
                    f.tok.idn  = idc;
                    f.ident    = 1'b1;
                end
            end
            MODE_NUMBER: begin
                f.valid    = 1'b1;
                f.tok.kind = KIND_NUMBER;
            end
            MODE_RELOP: begin
                f.valid    = 1'b1;
                f.tok.kind = KIND_RELOP;
                f.tok.len  = LEN_W'(1);
                f.tok.code = (rf == ">") ? REL_GT : (rf == "<") ? REL_LT : REL_UNK;
            end
            default: begin
                f.valid = 1'b0;
            end
        endcase
        return f;
    endfunction

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign c       = i_text_byte;
    assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign c_digit = (c >= "0" && c <= "9");
    assign c_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    assign c_under = (c == "_");

    always_comb begin
        n_mode    = r_mode;
        n_rf      = r_rf;
        n_km      = r_km;
        n_rl      = r_rl;
        n_rs      = r_rs;
        n_pos     = r_pos;
        n_idc     = r_idc;
        n_stopped = r_stopped;
        n_cnt     = 2'd0;
        tok_list[0] = '0;
        tok_list[1] = '0;
        f_a       = '0;
        f_b       = '0;
        f_c       = '0;
        consumed  = 1'b0;
        do_new    = 1'b0;

        if (accept) begin
            if (r_stopped) begin
                do_new = i_last_byte;
            end else if (c == 8'h00) begin
                f_a = flush_run(n_mode, n_km, n_rl, n_rs, n_rf, n_idc);
                if (f_a.valid) begin
                    tok_list[n_cnt[0]] = f_a.tok;
                    n_cnt = n_cnt + 2'd1;
                end
                if (f_a.ident) begin
                    n_idc = idn_inc(n_idc);
                end
                n_mode    = MODE_IDLE;
                n_stopped = 1'b1;
                do_new    = i_last_byte;
            end else begin
                if (n_mode == MODE_RELOP) begin
                    if (c == "=") begin
                        tok_list[n_cnt[0]].kind  = KIND_RELOP;
                        tok_list[n_cnt[0]].code  = (n_rf == ">") ? REL_GE :
                                                   (n_rf == "<") ? REL_LE :
                                                   (n_rf == "=") ? REL_EQ : REL_NE;
                        tok_list[n_cnt[0]].idn   = '0;
                        tok_list[n_cnt[0]].start = rep_pos(n_rs);
                        tok_list[n_cnt[0]].len   = LEN_W'(2);
                        n_cnt    = n_cnt + 2'd1;
                        n_mode   = MODE_IDLE;
                        consumed = 1'b1;
                    end else begin
                        f_a = flush_run(n_mode, n_km, n_rl, n_rs, n_rf, n_idc);
                        tok_list[n_cnt[0]] = f_a.tok;
                        n_cnt  = n_cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end
                end

                if (!consumed) begin
                    if ((n_mode == MODE_IDENT && (c_alpha || c_digit || c_under)) ||
                        (n_mode == MODE_NUMBER && (c_digit || c == "."))) begin
                        n_km = extend_match(n_km, n_rl, c);
                        n_rl = run_inc(n_rl);
                    end else begin
                        f_b = flush_run(n_mode, n_km, n_rl, n_rs, n_rf, n_idc);
                        if (f_b.valid) begin
                            tok_list[n_cnt[0]] = f_b.tok;
                            n_cnt = n_cnt + 2'd1;
                        end
                        if (f_b.ident) begin
                            n_idc = idn_inc(n_idc);
                        end
                        n_mode = MODE_IDLE;
                        priority if (c_alpha || c_under || c_digit) begin
                            n_mode = c_digit ? MODE_NUMBER : MODE_IDENT;
                            n_rs   = r_pos;
                            n_km   = extend_match({KW_COUNT{1'b1}}, '0, c);
                            n_rl   = run_inc('0);
                        end else if (c_space) begin
                            n_mode = MODE_IDLE;
                        end else if (c == ">" || c == "<" || c == "=" || c == "!") begin
                            n_mode = MODE_RELOP;
                            n_rf   = c;
                            n_rs   = r_pos;
                        end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
                            tok_list[n_cnt[0]] = one_byte(KIND_ARITH, c, r_pos);
                            n_cnt = n_cnt + 2'd1;
                        end else if (c == "(" || c == ")" || c == "{" || c == "}" ||
                                     c == ";") begin
                            tok_list[n_cnt[0]] = one_byte(KIND_SYMBOL, c, r_pos);
                            n_cnt = n_cnt + 2'd1;
                        end else begin
                            tok_list[n_cnt[0]] = one_byte(KIND_UNKNOWN, c, r_pos);
                            n_cnt = n_cnt + 2'd1;
                        end
                    end
                end

                if (r_pos < POS_LAST) begin
                    n_pos = r_pos + 1'b1;
                end

                if (i_last_byte) begin
                    f_c = flush_run(n_mode, n_km, n_rl, n_rs, n_rf, n_idc);
                    if (f_c.valid) begin
                        tok_list[n_cnt[0]] = f_c.tok;
                        n_cnt = n_cnt + 2'd1;
                    end
                    do_new = 1'b1;
                end
            end
        end

        if (do_new) begin
            n_mode    = MODE_IDLE;
            n_rf      = '0;
            n_km      = {KW_COUNT{1'b1}};
            n_rl      = '0;
            n_rs      = '0;
            n_pos     = '0;
            n_idc     = IDN_W'(1);
            n_stopped = 1'b0;
        end
    end

    assign o_push          = accept && (n_cnt != 2'd0);
    assign o_entry.has_two = n_cnt[1];
    assign o_entry.tok0    = tok_list[0];
    assign o_entry.tok1    = tok_list[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_rf      <= '0;
            r_km      <= {KW_COUNT{1'b1}};
            r_rl      <= '0;
            r_rs      <= '0;
            r_pos     <= '0;
            r_idc     <= IDN_W'(1);
            r_stopped <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_rf      <= n_rf;
            r_km      <= n_km;
            r_rl      <= n_rl;
            r_rs      <= n_rs;
            r_pos     <= n_pos;
            r_idc     <= n_idc;
            r_stopped <= n_stopped;
        end
    end

endmodule

FILE: hw/rtl/ltr_queue.sv
// Short queue of token entries between the scanner and the output stage.
`timescale 1ns / 1ps

module ltr_queue
    import ltr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_space,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QPTR_W:0]     r_count, n_count;

    assign o_space = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr    = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_pop) begin
            n_rd    = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/ltr_back.sv
// Output stage: sends the one or two tokens of each queue entry through a result register.
`timescale 1ns / 1ps

module ltr_back
    import ltr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_entry i_q_entry,
    output logic   o_q_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_tok,
    output logic   o_last
);

    logic   r_valid;
    logic   r_second;
    t_token r_tok;
    logic   r_last;
    logic   out_free;
    logic   load;

    assign out_free = !r_valid || i_ready;
    assign load     = out_free && i_q_valid;
    assign o_q_pop  = load && (r_second || !i_q_entry.has_two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= !r_second && i_q_entry.has_two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_second ? i_q_entry.tok1 : i_q_entry.tok0;
            r_last <= r_second || !i_q_entry.has_two;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

endmodule

FILE: hw/rtl/lexical_token_recognizer_unit.sv
// Top level of the lexical token recognizer: scanner, token queue and output stage.
`timescale 1ns / 1ps

// The block scans source text one byte per word on the input channel
// (i_valid / o_ready) and emits one token per word on the output channel
// (o_valid / i_ready). A byte may cause zero, one or two tokens; o_last_of_run
// marks the final token caused by a byte. A zero byte closes any open token and
// the rest of the text is dropped until a byte with i_last_byte set, which
// also starts a new text with position 0 and identifier number 1.
// Throughput: one byte per cycle on input while the queue has space, one token
// per cycle on output while i_ready is high. The scanner decides all tokens of
// a byte in the cycle it is accepted and writes them as one entry into a
// four-entry queue; the output stage takes an entry apart into one or two
// tokens. When the queue and output register are empty, the first token of a
// byte is written into the queue at its acceptance edge, then into the output
// register, where it can be taken. o_ready falls only while the queue is full,
// so a stalled receiver stalls the scanner once four entries wait in the
// queue. Reset (synchronous, active low) empties the queue and output register
// and returns the scanner to the start of a text. No configuration is needed.

module lexical_token_recognizer_unit
    import ltr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [KIND_W-1:0]  o_token_kind,
    output logic [CODE_W-1:0]  o_token_code,
    output logic [IDN_W-1:0]   o_ident_number,
    output logic [START_W-1:0] o_start_position,
    output logic [LEN_W-1:0]   o_token_length,
    output logic               o_last_of_run
);

    logic   q_space;
    logic   q_push;
    t_entry q_in;
    logic   q_valid;
    t_entry q_head;
    logic   q_pop;
    t_token out_tok;

    // Front end: classification and token state, one byte per cycle while q_space.
    ltr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_last_byte (i_last_byte),
        .i_space     (q_space),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    // Queue decouples byte acceptance from token delivery.
    ltr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_head)
    );

    // Back end: serializes each entry into tokens.
    ltr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_tok     (out_tok),
        .o_last    (o_last_of_run)
    );

    assign o_token_kind     = out_tok.kind;
    assign o_token_code     = out_tok.code;
    assign o_ident_number   = out_tok.idn;
    assign o_start_position = out_tok.start;
    assign o_token_length   = out_tok.len;

endmodule

FILE: tb/sv/lexical_token_scoreboard_pkg.sv
// Scoreboard class with the token predictor for the lexical token recognizer testbench.
`timescale 1ns / 1ps

package lexical_token_scoreboard_pkg;

    import ltr_pkg::*;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [IDN_W-1:0]   idn;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_lex_token;

    class token_scoreboard;

        typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_RELOP} t_scan_mode;

        localparam int KEYWORDS = 7;

        t_scan_mode   mode;
        logic [7:0]   relop_first;
        logic [6:0]   kw_live;
        int unsigned  run_len;
        int unsigned  run_begin;
        int unsigned  text_pos;
        int unsigned  next_ident;
        bit           stopped;
        string        kw_words [KEYWORDS];

        t_lex_token   expected_tokens [$];
        t_lex_token   step_tokens [$];

        int unsigned  failures;
        int unsigned  bytes_noted;
        int unsigned  tokens_checked;
        int unsigned  kind_seen [7];
        int unsigned  top_len;
        int unsigned  top_ident;
        int unsigned  top_start;

        function new();
            kw_words = '{"if", "then", "else", "while", "int", "float", "return"};
            restart_text();
        endfunction

        function void restart_text();
            mode        = SCAN_IDLE;
            relop_first = 8'h00;
            kw_live     = '1;
            run_len     = 0;
            run_begin   = 0;
            text_pos    = 0;
            next_ident  = 1;
            stopped     = 1'b0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void add_token(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                int unsigned idn, int unsigned start, int unsigned len);
            t_lex_token t;
            t.kind  = kind;
            t.code  = code;
            t.idn   = IDN_W'(idn);
            t.start = (start > 32'hFFFF) ? '1 : START_W'(start);
            t.len   = (len > 32'hFF) ? '1 : LEN_W'(len);
            t.last  = 1'b0;
            step_tokens.push_back(t);
        endfunction

        // Keyword candidates drop out as soon as a byte differs or the run outgrows them.
        function void grow_run(logic [7:0] c);
            for (int k = 0; k < KEYWORDS; k++) begin
                if (run_len >= kw_words[k].len() || kw_words[k][run_len] != c)
                    kw_live[k] = 1'b0;
            end
            if (run_len < MAX_TOKEN_BYTES)
                run_len++;
        endfunction

        function void begin_run(t_scan_mode m, logic [7:0] c);
            mode      = m;
            run_begin = text_pos;
            run_len   = 0;
            kw_live   = '1;
            grow_run(c);
        endfunction

        function void close_run();
            int hit;
            hit = -1;
            case (mode)
                SCAN_IDENT: begin
                    for (int k = 0; k < KEYWORDS && hit < 0; k++)
                        if (kw_live[k] && run_len == kw_words[k].len())
                            hit = k;
                    if (hit >= 0) begin
                        add_token(KIND_KEYWORD, CODE_W'(hit), 0, run_begin, run_len);
                    end else begin
                        add_token(KIND_IDENT, 8'h00, next_ident, run_begin, run_len);
                        if (next_ident < IDN_MAX)
                            next_ident++;
                    end
                end
                SCAN_NUMBER: begin
                    add_token(KIND_NUMBER, 8'h00, 0, run_begin, run_len);
                end
                SCAN_RELOP: begin
                    add_token(KIND_RELOP, (relop_first == ">") ? REL_GT :
                              (relop_first == "<") ? REL_LT : REL_UNK, 0, run_begin, 1);
                end
                default: begin
                end
            endcase
            mode = SCAN_IDLE;
        endfunction

        // Works out the tokens caused by one accepted byte and queues them.
        function void note_byte(logic [7:0] c, logic last);
            bit used;
            used = 1'b0;
            bytes_noted++;
            step_tokens.delete();
            if (stopped) begin
                if (last)
                    restart_text();
                return;
            end
            if (c == 8'h00) begin
                close_run();
                stopped = 1'b1;
                if (last)
                    restart_text();
            end else begin
                if (mode == SCAN_RELOP) begin
                    if (c == "=") begin
                        add_token(KIND_RELOP, (relop_first == ">") ? REL_GE :
                                  (relop_first == "<") ? REL_LE :
                                  (relop_first == "=") ? REL_EQ : REL_NE, 0, run_begin, 2);
                        mode = SCAN_IDLE;
                        used = 1'b1;
                    end else begin
                        close_run();
                    end
                end
                if (!used) begin
                    if (mode == SCAN_IDENT && (is_letter(c) || is_digit(c) || c == "_")) begin
                        grow_run(c);
                    end else if (mode == SCAN_NUMBER && (is_digit(c) || c == ".")) begin
                        grow_run(c);
                    end else begin
                        close_run();
                        if (is_letter(c) || c == "_") begin
                            begin_run(SCAN_IDENT, c);
                        end else if (is_digit(c)) begin
                            begin_run(SCAN_NUMBER, c);
                        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                            // Whitespace only separates tokens.
                        end else if (c == ">" || c == "<" || c == "=" || c == "!") begin
                            mode        = SCAN_RELOP;
                            relop_first = c;
                            run_begin   = text_pos;
                        end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
                            add_token(KIND_ARITH, c, 0, text_pos, 1);
                        end else if (c == "(" || c == ")" || c == "{" || c == "}" ||
                                     c == ";") begin
                            add_token(KIND_SYMBOL, c, 0, text_pos, 1);
                        end else begin
                            add_token(KIND_UNKNOWN, c, 0, text_pos, 1);
                        end
                    end
                end
                if (text_pos < TEXT_POSITIONS - 1)
                    text_pos++;
                if (last) begin
                    close_run();
                    restart_text();
                end
            end
            if (step_tokens.size() > 0)
                step_tokens[$].last = 1'b1;
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        endfunction

        function string describe(t_lex_token t);
            return $sformatf("kind %0d code %0d ident %0d start %0d len %0d last %0d",
                             t.kind, t.code, t.idn, t.start, t.len, t.last);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("[%0t] Token mismatch: %s", $time, msg);
        endfunction

        function int unsigned pending_count();
            return expected_tokens.size();
        endfunction

        // Compares one accepted token with the oldest expectation.
        function void check_token(t_lex_token got);
            t_lex_token want;
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
                note_failure({"none expected, got ", describe(got)});
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.code !== want.code || got.idn !== want.idn ||
                got.start !== want.start || got.len !== want.len ||
                got.last !== want.last) begin
                note_failure({"expected ", describe(want), " / got ", describe(got)});
            end else begin
                kind_seen[want.kind]++;
                if (want.len > top_len)
                    top_len = want.len;
                if (want.idn > top_ident)
                    top_ident = want.idn;
                if (want.start > top_start)
                    top_start = want.start;
            end
        endfunction

        function void flag_leftovers();
            while (expected_tokens.size() > 0)
                note_failure({"never received ", describe(expected_tokens.pop_front())});
        endfunction

    endclass

endpackage

FILE: tb/sv/lexical_token_recognizer_unit_tb.sv
// Self-checking testbench of the lexical token recognizer top level.
`timescale 1ns / 1ps

// Source text is pushed into the block one byte per word and every token word
// that comes out is compared against a software scanner kept in the scoreboard.
// The run has four parts: a short directed text that touches every token kind
// and the odd cases (lone '=' and '!', zero byte, bytes above 127, flush at the
// last byte), two tokens longer than the length field can hold, random texts
// built mostly from well-formed lexemes, and finally a short text sent at full
// rate. Both channels idle in random bursts except during that final text.

module lexical_token_recognizer_unit_tb;

    import ltr_pkg::*;
    import lexical_token_scoreboard_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 100_000;
    localparam int RANDOM_BYTES = 560;
    localparam int FINAL_PAIRS  = 40;
    localparam int LONG_RUN     = 260;
    // Margin for the path through the queue and the output register.
    localparam int SETTLE_CYCLES = 12;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [BYTE_W-1:0]  i_text_byte = '0;
    logic               i_last_byte = 1'b0;
    logic               i_ready     = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [KIND_W-1:0]  o_token_kind;
    logic [CODE_W-1:0]  o_token_code;
    logic [IDN_W-1:0]   o_ident_number;
    logic [START_W-1:0] o_start_position;
    logic [LEN_W-1:0]   o_token_length;
    logic               o_last_of_run;

    token_scoreboard lex_sb = new();
    t_lex_token      out_word;

    // Idling switches: the main process flips these per text.
    bit          send_idling = 1'b0;
    bit          take_idling = 1'b0;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    // Bytes of the text being sent next.
    logic [7:0]  text_q [$];
    string       kw_pool [7] = '{"if", "then", "else", "while", "int", "float", "return"};
    string       relop_pool [8] = '{">", "<", "=", "!", ">=", "<=", "==", "!="};

    lexical_token_recognizer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_text_byte      (i_text_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_token_kind     (o_token_kind),
        .o_token_code     (o_token_code),
        .o_ident_number   (o_ident_number),
        .o_start_position (o_start_position),
        .o_token_length   (o_token_length),
        .o_last_of_run    (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Monitor and watchdog. Both handshakes are judged on the values that were
    // present just before the edge, so the drivers' nonblocking updates at the
    // same edge cannot disturb them. An input word is noted before any output
    // word of the same edge is checked.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Cycle limit of %0d reached, %0d tokens outstanding",
                     CYCLE_LIMIT, lex_sb.pending_count());
            $display("Verification failed");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && o_ready)
                lex_sb.note_byte(i_text_byte, i_last_byte);
            if (o_valid && i_ready) begin
                out_word.kind  = o_token_kind;
                out_word.code  = o_token_code;
                out_word.idn   = o_ident_number;
                out_word.start = o_start_position;
                out_word.len   = o_token_length;
                out_word.last  = o_last_of_run;
                lex_sb.check_token(out_word);
            end
        end
    end

    // Receiver: while idling is on, i_ready drops at random and stays low while stall_left counts down.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (take_idling && $urandom_range(0, 4) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] ident_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] number_char();
        int r;
        r = $urandom_range(0, 10);
        return (r == 10) ? "." : 8'("0" + r);
    endfunction

    // One of the six whitespace bytes: space, tab, LF, VT, FF, CR.
    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'h20 : 8'(r);
    endfunction

    // Offers one word and returns at the edge where it is accepted. The
    // optional gap in front of it is the sender's idling.
    task automatic send_word(input logic [7:0] b, input logic last);
        if (send_idling && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_text_q(input bit mark_last);
        foreach (text_q[i])
            send_word(text_q[i], mark_last && i == text_q.size() - 1);
    endtask

    // The sender holds off until every expected token has come out. The first
    // edge lets the monitor note the word accepted last.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (lex_sb.pending_count() != 0)
            @(posedge i_clk);
    endtask

    function automatic void push_string(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    initial begin
        int    random_words;
        int    pick;
        int    cut;
        string kw_text;

        random_words = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        send_idling = 1'b1;
        take_idling = 1'b1;

        // Directed text: keyword, identifier with underscore and digit, a number
        // with a dot, GE, NE and an identifier closed by the last-byte flag.
        text_q.delete();
        push_string("if _a1>=2.5!=b");
        send_text_q(1'b1);
        // Bytes above 127, a lone '=' closed by a zero byte, then bytes that
        // are dropped until the last-byte flag starts a new text.
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word("=", 1'b0);
        send_word(8'h00, 1'b0);
        send_word("x", 1'b0);
        send_word(8'h7F, 1'b1);
        // A lone '!' and a '<' that is still open at the last byte.
        send_word("!", 1'b0);
        send_word("<", 1'b1);
        // A symbol and arithmetic operators, ended by a zero byte with the flag.
        send_word("(", 1'b0);
        send_word("-", 1'b0);
        send_word("/", 1'b0);
        send_word(8'h00, 1'b1);
        wait_drained();

        // Identifier and number runs longer than the length field can report.
        text_q.delete();
        text_q.push_back("q");
        repeat (LONG_RUN - 1) text_q.push_back(ident_char(1'b0));
        text_q.push_back(" ");
        text_q.push_back("7");
        repeat (LONG_RUN - 1) text_q.push_back(number_char());
        send_text_q(1'b1);

        // Random texts, mostly well-formed lexemes with random content plus
        // some noise bytes, keyword near-misses and zero-byte endings.
        while (random_words < RANDOM_BYTES) begin
            send_idling = ($urandom_range(0, 3) != 0);
            take_idling = ($urandom_range(0, 3) != 0);
            text_q.delete();
            repeat ($urandom_range(1, 12)) begin
                pick = $urandom_range(0, 99);
                if (pick < 18) begin
                    kw_text = kw_pool[$urandom_range(0, 6)];
                    case ($urandom_range(0, 4))
                        2: begin
                            push_string(kw_text);
                            text_q.push_back(ident_char(1'b0));
                        end
                        3: begin
                            cut = $urandom_range(1, kw_text.len() - 1);
                            for (int i = 0; i < cut; i++)
                                text_q.push_back(kw_text[i]);
                        end
                        4: begin
                            // Upper case first letter: must not match a keyword.
                            text_q.push_back(8'(kw_text[0] - 8'h20));
                            for (int i = 1; i < kw_text.len(); i++)
                                text_q.push_back(kw_text[i]);
                        end
                        default: push_string(kw_text);
                    endcase
                end else if (pick < 38) begin
                    text_q.push_back(ident_char(1'b1));
                    repeat ($urandom_range(0, 11)) text_q.push_back(ident_char(1'b0));
                end else if (pick < 55) begin
                    text_q.push_back(8'("0" + $urandom_range(0, 9)));
                    repeat ($urandom_range(0, 7)) text_q.push_back(number_char());
                end else if (pick < 70) begin
                    push_string(relop_pool[$urandom_range(0, 7)]);
                end else if (pick < 78) begin
                    kw_text = "+-*/";
                    text_q.push_back(kw_text[$urandom_range(0, 3)]);
                end else if (pick < 86) begin
                    kw_text = "(){};";
                    text_q.push_back(kw_text[$urandom_range(0, 4)]);
                end else if (pick < 92) begin
                    text_q.push_back(8'($urandom_range(1, 255)));
                end else begin
                    repeat ($urandom_range(1, 3)) text_q.push_back(blank_char());
                end
                if ($urandom_range(0, 9) < 6)
                    text_q.push_back(blank_char());
            end
            // Text ending: plain last byte, zero byte with the flag, or a zero
            // byte followed by dropped bytes before the flag.
            pick = $urandom_range(0, 19);
            if (pick >= 14)
                text_q.push_back(8'h00);
            if (pick >= 17)
                repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
            send_text_q(1'b1);
            random_words += text_q.size();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // One short text at full rate on both sides: a stream of identifiers,
        // then a keyword and a number closed by the last-byte flag.
        send_idling = 1'b0;
        take_idling = 1'b0;
        repeat (FINAL_PAIRS) begin
            send_word("a", 1'b0);
            send_word(" ", 1'b0);
        end
        send_word("i", 1'b0);
        send_word("f", 1'b0);
        send_word(" ", 1'b0);
        send_word("9", 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        lex_sb.flag_leftovers();

        $display("Scanned %0d bytes into %0d tokens: %0d keywords, %0d identifiers,",
                 lex_sb.bytes_noted, lex_sb.tokens_checked, lex_sb.kind_seen[0],
                 lex_sb.kind_seen[1]);
        $display("%0d numbers, %0d relops, %0d arith, %0d symbols, %0d unknown; max len %0d",
                 lex_sb.kind_seen[2], lex_sb.kind_seen[3], lex_sb.kind_seen[4],
                 lex_sb.kind_seen[5], lex_sb.kind_seen[6], lex_sb.top_len);
        if (lex_sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: lexical_token_recognizer_unit.f
hw/rtl/ltr_pkg.sv
hw/rtl/ltr_front.sv
hw/rtl/ltr_queue.sv
hw/rtl/ltr_back.sv
hw/rtl/lexical_token_recognizer_unit.sv
tb/sv/lexical_token_scoreboard_pkg.sv
tb/sv/lexical_token_recognizer_unit_tb.sv
